FILE: hw/rtl/i2r_pkg.sv
package i2r_pkg;

  // ASCII codes of the numeral letters.
  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_V = 8'h56;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_M = 8'h4D;
  localparam logic [7:0] CHAR_NONE = 8'h00;

  localparam logic [11:0] MAX_VALID = 12'd3999;

  // Decimal places, most significant first.
  localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
  localparam logic [1:0] PLACE_TENS      = 2'd2;
  localparam logic [1:0] PLACE_ONES      = 2'd3;

  typedef enum logic [1:0] {
    KIND_UNIT = 2'd0,
    KIND_FIVE = 2'd1,
    KIND_TEN  = 2'd2
  } kind_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic       err;
    logic [1:0] th;
    logic [3:0] hu;
    logic [3:0] te;
    logic [3:0] on;
  } item_t;

  // Number of letters that one decimal digit produces.
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Which of the unit, five and ten letters stands at position k of digit d.
  function automatic kind_t letter_kind(input logic [3:0] d, input logic [1:0] k);
    kind_t kd;
    kd = KIND_UNIT;
    if (d == 4'd9) begin
      kd = (k == 2'd0) ? KIND_UNIT : KIND_TEN;
    end else if (d >= 4'd5) begin
      kd = (k == 2'd0) ? KIND_FIVE : KIND_UNIT;
    end else if (d == 4'd4) begin
      kd = (k == 2'd0) ? KIND_UNIT : KIND_FIVE;
    end
    return kd;
  endfunction

  // Letter of a given kind at a given decimal place.
  function automatic logic [7:0] place_letter(input logic [1:0] place, input kind_t kd);
    logic [7:0] c;
    case (place)
      PLACE_THOUSANDS: c = CHAR_M;
      PLACE_HUNDREDS:  c = (kd == KIND_UNIT) ? CHAR_C : (kd == KIND_FIVE) ? CHAR_D : CHAR_M;
      PLACE_TENS:      c = (kd == KIND_UNIT) ? CHAR_X : (kd == KIND_FIVE) ? CHAR_L : CHAR_C;
      PLACE_ONES:      c = (kd == KIND_UNIT) ? CHAR_I : (kd == KIND_FIVE) ? CHAR_V : CHAR_X;
      default:         c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/i2r_front.sv
module i2r_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [11:0]         value,
  output logic                q_push,
  input  logic                q_full,
  output i2r_pkg::item_t      q_item
);

  logic       s1_valid;
  logic       s1_err;
  logic [1:0] s1_th;
  logic [9:0] s1_rem;
  logic       s2_valid;
  logic       s2_err;
  logic [1:0] s2_th;
  logic [3:0] s2_hu;
  logic [6:0] s2_rem;

  logic        adv;
  logic [1:0]  th_next;
  logic [11:0] rem1_full;
  logic [3:0]  hu_next;
  logic [9:0]  rem2_full;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  ones_full;

  // The whole front advances together; it holds when its last stage cannot drain.
  assign adv    = !s2_valid || !q_full;
  assign full   = !adv;
  assign q_push = s2_valid && !q_full;

  always_comb begin
    th_next = 2'd0;
    if (value >= 12'd3000) begin
      th_next = 2'd3;
    end else if (value >= 12'd2000) begin
      th_next = 2'd2;
    end else if (value >= 12'd1000) begin
      th_next = 2'd1;
    end
    rem1_full = value - (12'(th_next) * 12'd1000);
  end

  always_comb begin
    hu_next = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (s1_rem >= 10'(i * 100)) begin
        hu_next = 4'(i);
      end
    end
    rem2_full = s1_rem - (10'(hu_next) * 10'd100);
  end

  // Tens by reciprocal multiplication, exact for values below one hundred.
  always_comb begin
    tens_prod = 15'(s2_rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones_full = s2_rem - (7'(tens) * 7'd10);
    q_item.err = s2_err;
    q_item.th  = s2_th;
    q_item.hu  = s2_hu;
    q_item.te  = tens;
    q_item.on  = ones_full[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err <= (value == 12'd0) || (value > i2r_pkg::MAX_VALID);
      s1_th  <= th_next;
      s1_rem <= rem1_full[9:0];
      s2_err <= s1_err;
      s2_th  <= s1_th;
      s2_hu  <= hu_next;
      s2_rem <= rem2_full[6:0];
    end
  end

endmodule

FILE: hw/rtl/i2r_queue.sv
module i2r_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  i2r_pkg::item_t item_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output i2r_pkg::item_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  i2r_pkg::item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

FILE: hw/rtl/i2r_back.sv
module i2r_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  i2r_pkg::item_t q_item,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     symbol,
  output logic           last,
  output logic           error
);

  logic [1:0] place;
  logic [1:0] k;
  logic       out_valid;

  logic [3:0] digit [4];
  logic [2:0] len [4];
  logic [1:0] cp;
  logic       more;
  logic       digit_end;
  logic       load;
  logic [7:0] sym_next;
  logic       last_next;

  assign empty = !out_valid;
  assign load  = q_valid && (!out_valid || pop);

  always_comb begin
    digit[0] = {2'b00, q_item.th};
    digit[1] = q_item.hu;
    digit[2] = q_item.te;
    digit[3] = q_item.on;
    for (int p = 0; p < 4; p++) begin
      len[p] = i2r_pkg::digit_len(digit[p]);
    end
    // First place at or after the current one that produces letters.
    cp = place;
    for (int p = 3; p >= 0; p--) begin
      if ((2'(p) >= place) && (len[p] != 3'd0)) begin
        cp = 2'(p);
      end
    end
    more = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if ((2'(p) > cp) && (len[p] != 3'd0)) begin
        more = 1'b1;
      end
    end
    digit_end = ({1'b0, k} == (len[cp] - 3'd1));
    if (q_item.err) begin
      sym_next  = i2r_pkg::CHAR_NONE;
      last_next = 1'b1;
    end else begin
      sym_next  = i2r_pkg::place_letter(cp, i2r_pkg::letter_kind(digit[cp], k));
      last_next = digit_end && !more;
    end
  end

  assign q_pop = load && last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      place     <= i2r_pkg::PLACE_THOUSANDS;
      k         <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (last_next) begin
          place <= i2r_pkg::PLACE_THOUSANDS;
          k     <= 2'd0;
        end else if (digit_end) begin
          place <= cp + 2'd1;
          k     <= 2'd0;
        end else begin
          place <= cp;
          k     <= k + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      symbol <= sym_next;
      last   <= last_next;
      error  <= q_item.err;
    end
  end

endmodule

FILE: hw/rtl/integer_to_roman_numeral.sv
// Converts a 12-bit binary value into its Roman numeral, delivered as a run of
// ASCII letters (I V X L C D M), one letter per output transaction, with last
// set on the final letter. Values from 1 to 3999 give from one to fifteen
// letters; zero or anything above 3999 gives a single transaction with symbol
// 0, last 1 and error 1. Both sides behave as a queue: an input transaction
// completes on a rising edge with push high and full low, and an output
// transaction completes on a rising edge with pop high and empty low. A front
// with two register stages splits the value into decimal digits and can accept
// a new value every cycle unless the queue is full; a queue of QUEUE_DEPTH
// classified items decouples it from the back, which emits one letter per
// cycle while pop is held high. Throughput is therefore set by the back's
// letter sequencer, which holds a value until the last of its 1 to 15 letters
// is taken, so a steady stream at the input waits on the values ahead; short
// bursts are absorbed by the queue and the front. In an idle block a value
// passes both front stages and the queue before the output register takes its first letter.
module integer_to_roman_numeral #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [11:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  symbol,
  output logic        last,
  output logic        error
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  i2r_pkg::item_t q_in;
  i2r_pkg::item_t q_head;

  // Front: digit split of the incoming value and range check.
  i2r_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .value  (value),
    .q_push (q_push),
    .q_full (q_full),
    .q_item (q_in)
  );

  // Queue of classified items between front and back.
  i2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // Back: walks the digits and emits one letter per output transaction.
  i2r_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .symbol  (symbol),
    .last    (last),
    .error   (error)
  );

`ifndef SYNTHESIS
  // An error result always stands alone.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (last && (symbol == i2r_pkg::CHAR_NONE)))
    else $error("error result is not a single empty-symbol transaction");

  // Every letter of a valid numeral is a Roman letter.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !error) |-> ((symbol == i2r_pkg::CHAR_I) || (symbol == i2r_pkg::CHAR_V) ||
                            (symbol == i2r_pkg::CHAR_X) || (symbol == i2r_pkg::CHAR_L) ||
                            (symbol == i2r_pkg::CHAR_C) || (symbol == i2r_pkg::CHAR_D) ||
                            (symbol == i2r_pkg::CHAR_M)))
    else $error("symbol is not a numeral letter");

  // Once a numeral has started, its remaining letters follow without a gap.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> !empty)
    else $error("gap inside a numeral");

  // The back only retires items that the queue holds.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
